// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define LDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ldf_pkg.sv =====
package ldf_pkg;

  // Receive buffer capacity in bytes.
  localparam int BUF_SIZE = 4096;
  // Occupancy counter width: must hold BUF_SIZE itself.
  localparam int HELD_W   = $clog2(BUF_SIZE + 1);
  // Reported fill level width (fixed by the port).
  localparam int FILL_W   = 13;
  // Byte queue between front and back.
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
  // Header length in bytes, minus one (last header byte index).
  localparam int HDR_LAST = 3;

  // Head of the byte queue as seen by the back end.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } ldf_byte_t;

endpackage

// ===== rtl/core/ldf_rx_queue.sv =====
`include "assert_macros.svh"

module ldf_rx_queue
  import ldf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output ldf_byte_t  head,
  input  logic       pop
);

  logic [7:0]         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push;
  logic               do_pop;

  assign in_ready  = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign head.vld  = (cnt_r != '0);
  assign head.data = mem_r[rd_ptr_r];
  assign do_pop    = pop && head.vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_rx_byte;
    end
  end

  `LDF_ASSERT(a_q_cnt_bound, (cnt_r <= Q_CNT_W'(Q_DEPTH)), "queue count over depth")
  `LDF_ASSERT(a_q_ptr_gap, ((cnt_r == '0) || (cnt_r == Q_CNT_W'(Q_DEPTH))) |-> (wr_ptr_r == rd_ptr_r), "queue pointers disagree with count")

endmodule

// ===== rtl/core/ldf_engine.sv =====
`include "assert_macros.svh"

module ldf_engine
  import ldf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ldf_byte_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accepted,
  output logic              out_message_done,
  output logic [31:0]       out_message_length,
  output logic [31:0]       out_request_type,
  output logic [FILL_W-1:0] out_fill_level
);

  // Deframer state
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [1:0]        hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]       hdr_sh_r, hdr_sh_nxt;
  logic              known_r, known_nxt;
  logic [31:0]       plen_r, plen_nxt;
  logic [HELD_W-1:0] pseen_r, pseen_nxt;
  logic [31:0]       tsh_r, tsh_nxt;

  // Result register
  logic              out_valid_r;
  logic              acc_r, acc_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       mlen_r, mlen_nxt;
  logic [31:0]       rtype_r, rtype_nxt;
  logic [HELD_W-1:0] held_inc;
  logic [HELD_W-1:0] seen_inc;

  assign pop      = head.vld && (!out_valid_r || out_ready);
  assign held_inc = held_r + 1'b1;
  assign seen_inc = pseen_r + 1'b1;

  always_comb begin
    held_nxt    = held_r;
    hdr_cnt_nxt = hdr_cnt_r;
    hdr_sh_nxt  = hdr_sh_r;
    known_nxt   = known_r;
    plen_nxt    = plen_r;
    pseen_nxt   = pseen_r;
    tsh_nxt     = tsh_r;
    acc_nxt     = 1'b0;
    done_nxt    = 1'b0;
    mlen_nxt    = '0;
    rtype_nxt   = '0;
    if (held_r < HELD_W'(BUF_SIZE)) begin
      acc_nxt  = 1'b1;
      held_nxt = held_inc;
      if (!known_r) begin
        hdr_sh_nxt  = {hdr_sh_r[23:0], head.data};
        hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        if (hdr_cnt_r == 2'(HDR_LAST)) begin
          // header complete: free its four bytes
          held_nxt   = held_r - HELD_W'(HDR_LAST);
          plen_nxt   = {hdr_sh_r[23:0], head.data};
          hdr_sh_nxt = '0;
          pseen_nxt  = '0;
          tsh_nxt    = '0;
          if (plen_nxt == '0) begin
            done_nxt = 1'b1;
          end else begin
            known_nxt = 1'b1;
          end
        end
      end else begin
        pseen_nxt = seen_inc;
        if (pseen_r < HELD_W'(4)) begin
          tsh_nxt = {tsh_r[23:0], head.data};
        end
        if ({{(32-HELD_W){1'b0}}, seen_inc} == plen_r) begin
          done_nxt = 1'b1;
          mlen_nxt = plen_r;
          // short payload: left-align the bytes that exist
          case (seen_inc)
            HELD_W'(1): rtype_nxt = {tsh_nxt[7:0], 24'h0};
            HELD_W'(2): rtype_nxt = {tsh_nxt[15:0], 16'h0};
            HELD_W'(3): rtype_nxt = {tsh_nxt[23:0], 8'h0};
            default:    rtype_nxt = tsh_nxt;
          endcase
          held_nxt  = held_inc - plen_r[HELD_W-1:0];
          known_nxt = 1'b0;
          pseen_nxt = '0;
          tsh_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      hdr_cnt_r   <= '0;
      hdr_sh_r    <= '0;
      known_r     <= 1'b0;
      plen_r      <= '0;
      pseen_r     <= '0;
      tsh_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        held_r    <= held_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        hdr_sh_r  <= hdr_sh_nxt;
        known_r   <= known_nxt;
        plen_r    <= plen_nxt;
        pseen_r   <= pseen_nxt;
        tsh_r     <= tsh_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_r   <= acc_nxt;
      done_r  <= done_nxt;
      mlen_r  <= mlen_nxt;
      rtype_r <= rtype_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = acc_r;
  assign out_message_done   = done_r;
  assign out_message_length = mlen_r;
  assign out_request_type   = rtype_r;
  assign out_fill_level     = FILL_W'(held_r);

  `LDF_ASSERT(a_held_bound, (held_r <= HELD_W'(BUF_SIZE)), "buffer occupancy over capacity")
  `LDF_ASSERT(a_done_needs_acc, (out_valid_r && out_message_done) |-> out_accepted, "message completed by a dropped byte")
  `LDF_ASSERT(a_pseen_in_frame, (!known_r) |-> (pseen_r == '0), "payload count outside a frame")
  `LDF_ASSERT(a_result_held, (out_valid_r && !out_ready) |=> (out_valid_r && $stable(done_r) && $stable(mlen_r)), "stalled result changed")

endmodule

// ===== rtl/core/length_prefixed_message_deframer_top.sv =====
// Channel   Ports                                        Direction
// --------  -------------------------------------------  ---------
// input     in_valid, in_ready, in_rx_byte               into block
// result    out_valid, out_ready, out_accepted,          out of block
//           out_message_done, out_message_length,
//           out_request_type, out_fill_level
//
// One result per transfer on the input channel; sustained rate is one byte per
// clock while out_ready is high; the back end updates its state on every byte taken.
// out_valid follows the input transfer through the queue, then the result register.
// Synchronous active-low reset clears the queue, the deframer state and result valid.
// A stalled result channel backs up into the two-entry byte queue; in_ready drops
// only when that queue is full.
module length_prefixed_message_deframer_top
  import ldf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_accepted,
  output logic              out_message_done,
  output logic [31:0]       out_message_length,
  output logic [31:0]       out_request_type,
  output logic [FILL_W-1:0] out_fill_level
);

  ldf_byte_t head;   // oldest queued byte
  logic      pop;    // back end takes head this cycle

  // Front: registered byte queue, decouples input transfers from result stalls.
  ldf_rx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .head       (head),
    .pop        (pop)
  );

  // Back: header assembly, payload counting, occupancy and result register.
  ldf_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_message_done   (out_message_done),
    .out_message_length (out_message_length),
    .out_request_type   (out_request_type),
    .out_fill_level     (out_fill_level)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ldf_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 8;     // settle time after the last result
  localparam int RANDOM_BYTES = 1280;
  localparam int HOLD_CYCLES  = 300;   // long output hold-off
  localparam int RESET_CYCLES = 10;

  typedef struct packed {
    logic              accepted;
    logic              message_done;
    logic [31:0]       message_length;
    logic [31:0]       request_type;
    logic [FILL_W-1:0] fill_level;
  } deframe_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_accepted;
  logic              out_message_done;
  logic [31:0]       out_message_length;
  logic [31:0]       out_request_type;
  logic [FILL_W-1:0] out_fill_level;

  length_prefixed_message_deframer_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_message_done   (out_message_done),
    .out_message_length (out_message_length),
    .out_request_type   (out_request_type),
    .out_fill_level     (out_fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deframer state mirror
  // ---------------------------------------------------------------------------
  logic [FILL_W-1:0] held_cnt;
  logic [2:0]        hdr_cnt;
  logic [31:0]       hdr_acc;
  logic              in_payload;
  logic [31:0]       pay_len;
  logic [31:0]       pay_cnt;
  logic [31:0]       type_acc;

  deframe_result_t pending_results[$];

  int  fail_count     = 0;
  int  bytes_sent     = 0;
  int  messages       = 0;
  int  empty_messages = 0;
  int  dropped_bytes  = 0;
  int  peak_fill      = 0;
  int  quiet_cycles   = 0;
  int  stall_request  = 0;  // set by a test, consumed by the result monitor
  bit  tx_gaps_on     = 1'b1;
  bit  rx_stall_on    = 1'b1;

  task automatic clear_deframe_state();
    held_cnt   = '0;
    hdr_cnt    = '0;
    hdr_acc    = '0;
    in_payload = 1'b0;
    pay_len    = '0;
    pay_cnt    = '0;
    type_acc   = '0;
  endtask

  // Advance the mirror by one byte and return what the block should report.
  function automatic deframe_result_t deframe_step(input logic [7:0] b);
    deframe_result_t r;
    int n;
    r = '0;
    if (held_cnt < BUF_SIZE) begin
      r.accepted = 1'b1;
      held_cnt = held_cnt + 1'b1;
      if (!in_payload) begin
        hdr_acc = {hdr_acc[23:0], b};
        hdr_cnt = hdr_cnt + 1'b1;
        if (hdr_cnt >= 3'd4) begin
          // header complete: its four bytes leave the buffer
          hdr_cnt  = '0;
          held_cnt = held_cnt - FILL_W'(4);
          pay_len  = hdr_acc;
          hdr_acc  = '0;
          pay_cnt  = '0;
          type_acc = '0;
          if (pay_len == 0) begin
            r.message_done = 1'b1;  // empty message, length and type stay zero
          end else begin
            in_payload = 1'b1;
          end
        end
      end else begin
        pay_cnt = pay_cnt + 1;
        if (pay_cnt <= 4) type_acc = {type_acc[23:0], b};
        if (pay_cnt == pay_len) begin
          // short payloads leave the low bytes of the type at zero
          n = (pay_cnt < 4) ? int'(pay_cnt) : 4;
          r.message_done   = 1'b1;
          r.message_length = pay_len;
          r.request_type   = type_acc << (8 * (4 - n));
          held_cnt   = held_cnt - pay_len[FILL_W-1:0];
          in_payload = 1'b0;
          pay_cnt    = '0;
          type_acc   = '0;
        end
      end
    end
    r.fill_level = held_cnt;
    return r;
  endfunction

  // Mostly back to back, sometimes short gaps, rarely long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Leaves valid high after the transfer; the next call either reuses it at
  // once or lowers it for a gap, and wait_for_results lowers it before pausing.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    deframe_result_t r;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = deframe_step(b);
    pending_results.push_back(r);
    bytes_sent++;
    if (!r.accepted) dropped_bytes++;
    if (r.message_done) begin
      messages++;
      if (r.message_length == 0) empty_messages++;
    end
    if (r.fill_level > peak_fill) peak_fill = r.fill_level;
  endtask

  task automatic send_header(input logic [31:0] len);
    int i;
    for (i = 0; i < 4; i++) send_byte(len[31 - 8 * i -: 8]);
  endtask

  // pat < 0: random payload bytes, else every byte is pat.
  task automatic send_frame(input int len, input int pat);
    int i;
    send_header(len);
    for (i = 0; i < len; i++) send_byte(pat < 0 ? 8'($urandom_range(0, 255)) : 8'(pat));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    deframe_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with no byte outstanding");
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("accepted", want.accepted, out_accepted);
      check_field("message_done", want.message_done, out_message_done);
      check_field("message_length", want.message_length, out_message_length);
      check_field("request_type", want.request_type, out_request_type);
      check_field("fill_level", want.fill_level, out_fill_level);
    end
  endtask

  initial begin : result_monitor
    int stall_left;
    int g;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result();
      if (stall_request > 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        g = rx_stall_on ? pick_gap() : 0;
        if (g > 0) begin
          stall_left = g - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty message, one-byte payload of all ones, three-byte payload, and a
  // four-byte all-ones payload for the full request type.
  task automatic test_directed_frames();
    send_frame(0, 8'h00);
    send_frame(1, 8'hFF);
    send_frame(3, -1);
    send_frame(4, 8'hFF);
    wait_for_results();
  endtask

  // Well-formed frames with random payloads; lengths stay within the buffer so
  // the stream never locks up. Idling modes change now and then.
  task automatic test_random_frames();
    int start;
    int len;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_gaps_on  = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 8)       len = 0;
      else if (r < 45) len = $urandom_range(1, 4);
      else if (r < 90) len = $urandom_range(5, 24);
      else if (r < 99) len = $urandom_range(25, 120);
      else             len = $urandom_range(121, 700);
      send_frame(len, -1);
    end
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    wait_for_results();
  endtask

  // Output held off while bytes keep coming, so the queue fills and in_ready
  // drops; then the sender pauses until everything has drained.
  task automatic test_backpressure();
    tx_gaps_on    = 1'b0;
    stall_request = HOLD_CYCLES;
    send_frame(40, -1);
    wait_for_results();
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    rst_n      <= 1'b0;
    clear_deframe_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_frames();
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Sent %0d bytes: %0d messages (%0d empty), %0d dropped on a full buffer.",
             bytes_sent, messages, empty_messages, dropped_bytes);
    $display("Peak fill %0d; short payloads, random idling and output hold-off exercised.",
             peak_fill);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== length_prefixed_message_deframer_top.f =====
+incdir+rtl/core
rtl/core/ldf_pkg.sv
rtl/core/ldf_rx_queue.sv
rtl/core/ldf_engine.sv
rtl/core/length_prefixed_message_deframer_top.sv
tb/testbench.sv
